// File: design/assert_macros.svh
// assertion macros for the design checker seqrw_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/seqrw_pkg.sv
package seqrw_pkg;

   localparam int SLOTS_DEFAULT        = 64;
   localparam int RING_ENTRIES_DEFAULT = 128;

   localparam int SEQ_W     = 32;
   localparam int PAYLOAD_W = 64;
   localparam int LENGTH_W  = 16;
   localparam int BYTES_W   = 23;

   localparam logic [BYTES_W-1:0] BYTES_MAX = '1;

   typedef enum logic {
      CMD_ENQUEUE = 1'b0,
      CMD_DEQUEUE = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      REASON_NONE      = 2'd0,
      REASON_WINDOW    = 2'd1,
      REASON_DUPLICATE = 2'd2
   } reason_type;

   typedef struct packed {
      cmd_type                cmd;
      logic [SEQ_W-1:0]       seq_number;
      logic [PAYLOAD_W-1:0]   payload;
      logic [LENGTH_W-1:0]    data_length;
   } req_type;

   typedef struct packed {
      logic                   accepted;
      reason_type             reject_reason;
      logic                   front_valid;
      logic [LENGTH_W-1:0]    front_length;
      logic [PAYLOAD_W-1:0]   front_payload;
      logic [SEQ_W-1:0]       next_expected;
      logic [BYTES_W-1:0]     bytes_held;
   } rsp_type;

endpackage

// File: design/sequence_reorder_window.sv
// sequence_reorder_window
// Reorder window for sequence-numbered packets. One request beat on req_*
// is either an enqueue (seq_number, payload, data_length) or a dequeue of
// the head slot; every request gives exactly one response beat on rsp_*
// carrying the accept status and the head slot's contents after the step.
// Both channels are valid/ready; a beat moves when valid and ready are high.
// Steps, from request accept to response valid:
//    enqueue: window check, slot lookup and write if free, head read, response
//       (no lookup when outside the window or the ring is full)
//    dequeue: head slot mark, reclaim of delivered ring entries, head read, response
// One request is in flight at a time; req_ready is high only while the
// sequencer is idle. All steps go through the slot table and the ring
// memories, one access each per cycle.
// The response register lets the next request be taken while a response
// waits; if the receiver stalls, the next request finishes its work and
// then holds in its last step until the response register is free.
// After reset the slot table is cleared one slot per cycle, during which
// req_ready stays low. The window then starts at 1.
module sequence_reorder_window #(
   parameter int SLOTS        = seqrw_pkg::SLOTS_DEFAULT,
   parameter int RING_ENTRIES = seqrw_pkg::RING_ENTRIES_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  seqrw_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output seqrw_pkg::rsp_type rsp_data
);

   localparam int SLOT_W = $clog2(SLOTS);
   localparam int RIDX_W = $clog2(RING_ENTRIES);
   localparam int USED_W = $clog2(RING_ENTRIES + 1);
   localparam int BYTE_W = $clog2(RING_ENTRIES * (2 ** seqrw_pkg::LENGTH_W - 1) + 1);
   localparam int CMP_W  = (BYTE_W > seqrw_pkg::BYTES_W) ? BYTE_W : seqrw_pkg::BYTES_W;

   localparam logic [SLOT_W-1:0]          SLOT_LAST = SLOT_W'(SLOTS - 1);
   localparam logic [SLOT_W:0]            SLOT_SPAN = (SLOT_W + 1)'(SLOTS);
   localparam logic [RIDX_W-1:0]          RING_LAST = RIDX_W'(RING_ENTRIES - 1);
   localparam logic [USED_W-1:0]          RING_FULL = USED_W'(RING_ENTRIES);
   localparam logic [seqrw_pkg::SEQ_W-1:0] SLOTS_SEQ = seqrw_pkg::SEQ_W'(SLOTS);

   typedef struct packed {
      logic              valid;
      logic [RIDX_W-1:0] index;
   } slot_type;

   typedef struct packed {
      logic [seqrw_pkg::PAYLOAD_W-1:0] payload;
      logic [seqrw_pkg::LENGTH_W-1:0]  length;
   } entry_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIFF,
      ST_SLOT,
      ST_LOOK,
      ST_DQ_READ,
      ST_DQ_MARK,
      ST_RC_READ,
      ST_RC_CHECK,
      ST_FR_SLOT,
      ST_FR_RING,
      ST_RESP
   } state_type;

   // slot table
   slot_type          slot_mem [SLOTS];
   slot_type          slot_rd_ff;
   logic              slot_we;
   logic              slot_re;
   logic [SLOT_W-1:0] slot_waddr;
   logic [SLOT_W-1:0] slot_raddr;
   slot_type          slot_wdata;

   // ring entries
   entry_type         entry_mem [RING_ENTRIES];
   entry_type         entry_rd_ff;
   logic              entry_we;
   logic              entry_re;
   logic [RIDX_W-1:0] entry_raddr;
   entry_type         entry_wdata;

   // delivered flags, written on every accepted enqueue so live entries never read stale
   logic              dlv_mem [RING_ENTRIES];
   logic              dlv_rd_ff;
   logic              dlv_we;
   logic              dlv_re;
   logic [RIDX_W-1:0] dlv_waddr;
   logic              dlv_wdata;

   state_type                      state_ff, state_in;
   logic [SLOT_W-1:0]              clr_ff, clr_in;
   seqrw_pkg::req_type             req_ff, req_in;
   logic                           in_window_ff, in_window_in;
   logic [SLOT_W-1:0]              diff_lo_ff, diff_lo_in;
   logic [SLOT_W-1:0]              cur_slot_ff, cur_slot_in;
   seqrw_pkg::reason_type          reason_ff, reason_in;
   logic                           front_valid_ff, front_valid_in;
   logic [SLOT_W-1:0]              slot_head_ff, slot_head_in;
   logic [RIDX_W-1:0]              ring_head_ff, ring_head_in;
   logic [RIDX_W-1:0]              ring_tail_ff, ring_tail_in;
   logic [USED_W-1:0]              used_ff, used_in;
   logic [seqrw_pkg::SEQ_W-1:0]    window_ff, window_in;
   logic [BYTE_W-1:0]              bytes_ff, bytes_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   seqrw_pkg::rsp_type             rsp_ff, rsp_in;

   logic [seqrw_pkg::SEQ_W-1:0]    diff;
   logic [SLOT_W:0]                slot_sum;
   logic [SLOT_W-1:0]              slot_pick;
   logic [SLOT_W-1:0]              slot_head_next;
   logic [RIDX_W-1:0]              ring_head_next;
   logic [RIDX_W-1:0]              ring_tail_next;
   logic [CMP_W-1:0]               bytes_wide;
   logic [seqrw_pkg::BYTES_W-1:0]  bytes_sat;

   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_waddr] <= slot_wdata;
      end
      if (slot_re) begin
         slot_rd_ff <= slot_mem[slot_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (entry_we) begin
         entry_mem[ring_tail_ff] <= entry_wdata;
      end
      if (entry_re) begin
         entry_rd_ff <= entry_mem[entry_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (dlv_we) begin
         dlv_mem[dlv_waddr] <= dlv_wdata;
      end
      if (dlv_re) begin
         dlv_rd_ff <= dlv_mem[ring_head_ff];
      end
   end

   assign diff           = req_ff.seq_number - window_ff;
   assign slot_sum       = {1'b0, slot_head_ff} + {1'b0, diff_lo_ff};
   assign slot_pick      = (slot_sum >= SLOT_SPAN) ? SLOT_W'(slot_sum - SLOT_SPAN)
                                                   : slot_sum[SLOT_W-1:0];
   assign slot_head_next = (slot_head_ff == SLOT_LAST) ? '0 : slot_head_ff + 1'b1;
   assign ring_head_next = (ring_head_ff == RING_LAST) ? '0 : ring_head_ff + 1'b1;
   assign ring_tail_next = (ring_tail_ff == RING_LAST) ? '0 : ring_tail_ff + 1'b1;

   assign bytes_wide = CMP_W'(bytes_ff);
   assign bytes_sat  = (bytes_wide > CMP_W'(seqrw_pkg::BYTES_MAX))
                       ? seqrw_pkg::BYTES_MAX : seqrw_pkg::BYTES_W'(bytes_wide);

   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      req_in         = req_ff;
      in_window_in   = in_window_ff;
      diff_lo_in     = diff_lo_ff;
      cur_slot_in    = cur_slot_ff;
      reason_in      = reason_ff;
      front_valid_in = front_valid_ff;
      slot_head_in   = slot_head_ff;
      ring_head_in   = ring_head_ff;
      ring_tail_in   = ring_tail_ff;
      used_in        = used_ff;
      window_in      = window_ff;
      bytes_in       = bytes_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_in         = rsp_ff;

      slot_we     = 1'b0;
      slot_re     = 1'b0;
      slot_waddr  = slot_head_ff;
      slot_raddr  = slot_head_ff;
      slot_wdata  = '0;
      entry_we    = 1'b0;
      entry_re    = 1'b0;
      entry_raddr = ring_head_ff;
      entry_wdata = '{payload: req_ff.payload, length: req_ff.data_length};
      dlv_we      = 1'b0;
      dlv_re      = 1'b0;
      dlv_waddr   = ring_tail_ff;
      dlv_wdata   = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            slot_we    = 1'b1;
            slot_waddr = clr_ff;
            if (clr_ff == SLOT_LAST) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               req_in    = req_data;
               reason_in = seqrw_pkg::REASON_NONE;
               state_in  = (req_data.cmd == seqrw_pkg::CMD_DEQUEUE) ? ST_DQ_READ : ST_DIFF;
            end
         end
         ST_DIFF: begin
            in_window_in = diff < SLOTS_SEQ;
            diff_lo_in   = diff[SLOT_W-1:0];
            state_in     = ST_SLOT;
         end
         ST_SLOT: begin
            if (!in_window_ff || used_ff >= RING_FULL) begin
               reason_in = seqrw_pkg::REASON_WINDOW;
               state_in  = ST_FR_SLOT;
            end else begin
               slot_re     = 1'b1;
               slot_raddr  = slot_pick;
               cur_slot_in = slot_pick;
               state_in    = ST_LOOK;
            end
         end
         ST_LOOK: begin
            if (slot_rd_ff.valid) begin
               reason_in = seqrw_pkg::REASON_DUPLICATE;
            end else begin
               slot_we      = 1'b1;
               slot_waddr   = cur_slot_ff;
               slot_wdata   = '{valid: 1'b1, index: ring_tail_ff};
               entry_we     = 1'b1;
               dlv_we       = 1'b1;
               ring_tail_in = ring_tail_next;
               used_in      = used_ff + 1'b1;
               bytes_in     = bytes_ff + BYTE_W'(req_ff.data_length);
            end
            state_in = ST_FR_SLOT;
         end
         ST_DQ_READ: begin
            slot_re  = 1'b1;
            state_in = ST_DQ_MARK;
         end
         ST_DQ_MARK: begin
            if (slot_rd_ff.valid) begin
               dlv_we    = 1'b1;
               dlv_waddr = slot_rd_ff.index;
               dlv_wdata = 1'b1;
               slot_we   = 1'b1;
            end
            slot_head_in = slot_head_next;
            window_in    = window_ff + 1'b1;
            state_in     = ST_RC_READ;
         end
         ST_RC_READ: begin
            if (used_ff != '0) begin
               dlv_re   = 1'b1;
               entry_re = 1'b1;
               state_in = ST_RC_CHECK;
            end else begin
               state_in = ST_FR_SLOT;
            end
         end
         ST_RC_CHECK: begin
            if (dlv_rd_ff) begin
               bytes_in     = bytes_ff - BYTE_W'(entry_rd_ff.length);
               ring_head_in = ring_head_next;
               used_in      = used_ff - 1'b1;
               state_in     = ST_RC_READ;
            end else begin
               state_in = ST_FR_SLOT;
            end
         end
         ST_FR_SLOT: begin
            slot_re  = 1'b1;
            state_in = ST_FR_RING;
         end
         ST_FR_RING: begin
            front_valid_in = slot_rd_ff.valid;
            if (slot_rd_ff.valid) begin
               entry_re    = 1'b1;
               entry_raddr = slot_rd_ff.index;
            end
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.accepted      = (reason_ff == seqrw_pkg::REASON_NONE);
               rsp_in.reject_reason = reason_ff;
               rsp_in.front_valid   = front_valid_ff;
               rsp_in.front_length  = front_valid_ff ? entry_rd_ff.length : '0;
               rsp_in.front_payload = front_valid_ff ? entry_rd_ff.payload : '0;
               rsp_in.next_expected = window_ff;
               rsp_in.bytes_held    = bytes_sat;
               rsp_valid_in         = 1'b1;
               state_in             = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         slot_head_ff <= '0;
         ring_head_ff <= '0;
         ring_tail_ff <= '0;
         used_ff      <= '0;
         window_ff    <= seqrw_pkg::SEQ_W'(1);
         bytes_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         slot_head_ff <= slot_head_in;
         ring_head_ff <= ring_head_in;
         ring_tail_ff <= ring_tail_in;
         used_ff      <= used_in;
         window_ff    <= window_in;
         bytes_ff     <= bytes_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff         <= req_in;
      in_window_ff   <= in_window_in;
      diff_lo_ff     <= diff_lo_in;
      cur_slot_ff    <= cur_slot_in;
      reason_ff      <= reason_in;
      front_valid_ff <= front_valid_in;
      rsp_ff         <= rsp_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: design/seqrw_checker.sv
`include "assert_macros.svh"

module seqrw_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input seqrw_pkg::rsp_type rsp_data
);

   // stalled response beat holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "response changed while stalled")

   // accept flag agrees with reject reason
   `ASSERT_IMPLIES(a_accept_code, clock, reset, rsp_valid, rsp_data.accepted == (rsp_data.reject_reason == seqrw_pkg::REASON_NONE), "accepted disagrees with reject_reason")

   // empty head slot reports zero fields
   `ASSERT_IMPLIES(a_empty_front, clock, reset, rsp_valid && !rsp_data.front_valid, rsp_data.front_length == '0 && rsp_data.front_payload == '0, "empty head slot with nonzero fields")

   // one request in flight
   `ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready, "request taken while busy")

endmodule

bind sequence_reorder_window seqrw_checker u_seqrw_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// File: verif/reorder_window_checker.sv
`timescale 1ns / 1ps
module reorder_window_checker
   import seqrw_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      failures,
   output int      outstanding
);

   localparam int SLOTS = SLOTS_DEFAULT;
   localparam int RING  = RING_ENTRIES_DEFAULT;

   bit                   slot_full  [SLOTS];
   int                   slot_entry [SLOTS];
   logic [PAYLOAD_W-1:0] entry_word [RING];
   logic [LENGTH_W-1:0]  entry_len  [RING];
   bit                   entry_done [RING];
   int                   slot_head;
   int                   ring_head;
   int                   ring_tail;
   int                   ring_used;
   logic [SEQ_W-1:0]     window_start;
   longint               held_bytes;
   int                   mismatches = 0;
   rsp_type              status_due[$];

   task automatic clear_window();
      for (int i = 0; i < SLOTS; i++) begin
         slot_full[i]  = 1'b0;
         slot_entry[i] = 0;
      end
      for (int i = 0; i < RING; i++) begin
         entry_word[i] = '0;
         entry_len[i]  = '0;
         entry_done[i] = 1'b0;
      end
      slot_head    = 0;
      ring_head    = 0;
      ring_tail    = 0;
      ring_used    = 0;
      window_start = 32'd1;
      held_bytes   = 0;
   endtask

   task automatic window_step(input req_type beat, output rsp_type status);
      logic [SEQ_W-1:0] offset;
      int               slot;
      int               head_entry;
      reason_type       why;
      why = REASON_NONE;
      if (beat.cmd == CMD_DEQUEUE) begin
         if (slot_full[slot_head]) begin
            entry_done[slot_entry[slot_head]] = 1'b1;
            slot_full[slot_head] = 1'b0;
         end
         slot_head = (slot_head + 1) % SLOTS;
         // reclaim delivered entries from the ring front, in order
         while (ring_used > 0 && entry_done[ring_head]) begin
            held_bytes            -= entry_len[ring_head];
            entry_done[ring_head]  = 1'b0;
            ring_head              = (ring_head + 1) % RING;
            ring_used--;
         end
         window_start = window_start + 32'd1;
      end else begin
         offset = beat.seq_number - window_start;
         if (offset >= SLOTS || ring_used >= RING) begin
            why = REASON_WINDOW;
         end else begin
            slot = (slot_head + int'(offset)) % SLOTS;
            if (slot_full[slot]) begin
               why = REASON_DUPLICATE;
            end else begin
               entry_word[ring_tail] = beat.payload;
               entry_len[ring_tail]  = beat.data_length;
               entry_done[ring_tail] = 1'b0;
               slot_full[slot]       = 1'b1;
               slot_entry[slot]      = ring_tail;
               ring_tail             = (ring_tail + 1) % RING;
               ring_used++;
               held_bytes += beat.data_length;
            end
         end
      end
      status.accepted      = (why == REASON_NONE);
      status.reject_reason = why;
      if (slot_full[slot_head]) begin
         head_entry           = slot_entry[slot_head];
         status.front_valid   = 1'b1;
         status.front_length  = entry_len[head_entry];
         status.front_payload = entry_word[head_entry];
      end else begin
         status.front_valid   = 1'b0;
         status.front_length  = '0;
         status.front_payload = '0;
      end
      status.next_expected = window_start;
      status.bytes_held    = (held_bytes > BYTES_MAX) ? BYTES_MAX : held_bytes[BYTES_W-1:0];
   endtask

   function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         clear_window();
         status_due.delete();
      end else begin
         if (req_valid && req_ready) begin
            window_step(req_data, want);
            status_due.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            if (status_due.size() == 0) begin
               $error("response beat with no request pending");
               mismatches++;
            end else begin
               want = status_due.pop_front();
               check_field("accepted", want.accepted, rsp_data.accepted);
               check_field("reject_reason", want.reject_reason, rsp_data.reject_reason);
               check_field("front_valid", want.front_valid, rsp_data.front_valid);
               check_field("front_length", want.front_length, rsp_data.front_length);
               check_field("front_payload", want.front_payload, rsp_data.front_payload);
               check_field("next_expected", want.next_expected, rsp_data.next_expected);
               check_field("bytes_held", want.bytes_held, rsp_data.bytes_held);
            end
         end
      end
      failures    <= mismatches;
      outstanding <= status_due.size();
   end

endmodule

// File: verif/sequence_reorder_window_tb.sv
`timescale 1ns / 1ps
module sequence_reorder_window_tb;
   import seqrw_pkg::*;

   localparam int RANDOM_BEATS   = 1130;
   localparam int SETTLE_CYCLES  = 300;
   localparam int WATCHDOG_LIMIT = 2000;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   req_type          req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   rsp_type          rsp_data;
   int               failures;
   int               outstanding;
   int               burst_left  = 0;
   int               stall_left  = 0;
   int               flow_left   = 0;
   int               idle_cycles = 0;
   logic [SEQ_W-1:0] head_seq    = 32'd1;

   initial begin
      forever #6 clock = ~clock;
   end

   sequence_reorder_window u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   reorder_window_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .failures    (failures),
      .outstanding (outstanding)
   );

   function automatic req_type enqueue_beat(logic [SEQ_W-1:0] seq, logic [PAYLOAD_W-1:0] word,
                                            logic [LENGTH_W-1:0] len);
      req_type beat;
      beat.cmd         = CMD_ENQUEUE;
      beat.seq_number  = seq;
      beat.payload     = word;
      beat.data_length = len;
      return beat;
   endfunction

   function automatic req_type dequeue_beat();
      req_type beat;
      beat     = enqueue_beat($urandom, {$urandom, $urandom}, LENGTH_W'($urandom));
      beat.cmd = CMD_DEQUEUE;
      return beat;
   endfunction

   function automatic logic [LENGTH_W-1:0] pick_length();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return LENGTH_W'($urandom);
      endcase
   endfunction

   task automatic send_beat(input req_type beat);
      int gap;
      if (burst_left == 0) begin
         gap        = $urandom_range(0, 10);
         burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 30);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (req_ready !== 1'b1);
      if (beat.cmd == CMD_DEQUEUE) head_seq++;
   endtask

   // receiver stalls in runs
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (flow_left > 0) begin
         flow_left <= flow_left - 1;
         rsp_ready <= 1'b1;
      end else begin
         stall_left <= ($urandom_range(0, 2) == 0) ? $urandom_range(1, 16) : 0;
         flow_left  <= ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(0, 40);
         rsp_ready  <= 1'($urandom_range(0, 1));
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      int               pick;
      logic [SEQ_W-1:0] seq;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // out of order fill, duplicate, window edges
      send_beat(enqueue_beat(32'd3, 64'hA5A5_5A5A_0F0F_F0F0, 16'd1));
      send_beat(enqueue_beat(32'd2, '1, '1));
      send_beat(enqueue_beat(32'd1, '0, '0));
      send_beat(enqueue_beat(32'd1, 64'd1, 16'd7));
      send_beat(enqueue_beat(32'd65, {$urandom, $urandom}, LENGTH_W'($urandom)));
      send_beat(enqueue_beat(32'd0, {$urandom, $urandom}, LENGTH_W'($urandom)));
      send_beat(enqueue_beat(32'hFFFF_FFFF, '1, '1));
      send_beat(enqueue_beat(32'h8000_0001, {$urandom, $urandom}, LENGTH_W'($urandom)));
      send_beat(enqueue_beat(32'd64, {$urandom, $urandom}, LENGTH_W'($urandom)));
      // in order delivery, chained reclaim, then an empty head
      repeat (4) send_beat(dequeue_beat());
      // slot index wraps past the table end
      send_beat(enqueue_beat(head_seq + 32'd63, {$urandom, $urandom}, LENGTH_W'($urandom)));
      send_beat(enqueue_beat(head_seq + 32'd62, {$urandom, $urandom}, LENGTH_W'($urandom)));
      send_beat(enqueue_beat(head_seq, {$urandom, $urandom}, LENGTH_W'($urandom)));
      send_beat(dequeue_beat());
      send_beat(dequeue_beat());

      for (int n = 0; n < RANDOM_BEATS; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            send_beat(enqueue_beat($urandom, {$urandom, $urandom}, pick_length()));
         end else if (pick < 12) begin
            seq = ($urandom_range(0, 1) == 1) ? head_seq + $urandom_range(64, 80)
                                               : head_seq - $urandom_range(1, 8);
            send_beat(enqueue_beat(seq, {$urandom, $urandom}, pick_length()));
         end else if (pick < 56) begin
            seq = head_seq + (($urandom_range(0, 9) < 7) ? $urandom_range(0, 15)
                                                          : $urandom_range(0, 63));
            send_beat(enqueue_beat(seq, {$urandom, $urandom}, pick_length()));
         end else begin
            send_beat(dequeue_beat());
         end
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+design
design/seqrw_pkg.sv
design/sequence_reorder_window.sv
design/seqrw_checker.sv
verif/reorder_window_checker.sv
verif/sequence_reorder_window_tb.sv
